### rtl/core/hsfp_pkg.sv
// Package with shared types, field step codes and status codes of the SPS field parser.
`timescale 1ns / 1ps
`default_nettype none

package hsfp_pkg;

  // Longest run of leading zeros that an exp-Golomb code may have.
  localparam logic [5:0] MAX_LEADING_ZEROS = 6'd31;
  // Number of header bytes (profile, flags, level) skipped before the first code.
  localparam logic [1:0] HEADER_SKIP_BYTES = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POC  = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_LONG_EXP = 2'd3;

  // Field step codes: which SPS syntax element is decoded next.
  localparam logic [3:0] STEP_SPS_ID     = 4'd0;
  localparam logic [3:0] STEP_FRAME_NUM  = 4'd1;
  localparam logic [3:0] STEP_POC_TYPE   = 4'd2;
  localparam logic [3:0] STEP_POC_LSB    = 4'd3;
  localparam logic [3:0] STEP_DELTA_FLAG = 4'd4;
  localparam logic [3:0] STEP_OFS_NONREF = 4'd5;
  localparam logic [3:0] STEP_OFS_T2B    = 4'd6;
  localparam logic [3:0] STEP_CYCLE_LEN  = 4'd7;
  localparam logic [3:0] STEP_CYCLE_ITEM = 4'd8;
  localparam logic [3:0] STEP_REF_FRAMES = 4'd9;
  localparam logic [3:0] STEP_GAPS_FLAG  = 4'd10;
  localparam logic [3:0] STEP_MB_WIDTH   = 4'd11;
  localparam logic [3:0] STEP_MB_HEIGHT  = 4'd12;
  localparam logic [3:0] STEP_MBS_FLAG   = 4'd13;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [1:0]  skip_cnt;
    logic [3:0]  step;
    logic [5:0]  lz_cnt;
    logic [5:0]  suffix_left;
    logic [31:0] code;
    logic [31:0] cycle_left;
    logic [5:0]  fn_size;
    logic [1:0]  poc_kind;
    logic [5:0]  lsb_size;
    logic        done;
  } parse_state_t;

  // Outcome of one decoded bit.
  typedef struct packed {
    logic       emit;
    logic [1:0] status;
    logic       mbs;
  } bit_res_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] frame_num_bits;
    logic [1:0] poc_mode;
    logic [5:0] poc_lsb_bits;
    logic       frame_mbs_only;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/hsfp_in_if.sv
// Byte input channel of the SPS field parser.
`timescale 1ns / 1ps
`default_nettype none

interface hsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

`default_nettype wire

### rtl/core/hsfp_out_if.sv
// Result output channel of the SPS field parser.
`timescale 1ns / 1ps
`default_nettype none

interface hsfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] frame_num_bits;
  logic [1:0] poc_mode;
  logic [5:0] poc_lsb_bits;
  logic       frame_mbs_only;

  modport source (output valid, output status, output frame_num_bits, output poc_mode,
                  output poc_lsb_bits, output frame_mbs_only, input ready);
  modport sink (input valid, input status, input frame_num_bits, input poc_mode,
                input poc_lsb_bits, input frame_mbs_only, output ready);
endinterface

`default_nettype wire

### rtl/core/h264_sps_field_parser.sv
// Top level of the H.264 SPS field parser: input register, byte decode and result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes SPS payload bytes, one per transfer, and gives at most one result per SPS: the
// frame number size, POC type, POC LSB size and frame_mbs_only with status OK, or an
// error status (invalid POC type, truncated input, exp-Golomb code too long). A byte
// with first_byte set restarts the parse; the three header bytes are skipped. One byte
// is taken every cycle while results are taken: all eight bits of a byte are decoded by
// a chain of eight unrolled bit-decode steps between the input register and the result
// register, so a result is valid once the byte that ends the parse has passed through
// both registers. While a result waits, the next byte waits in the input register.
// Emulation-prevention bytes are not removed.
module h264_sps_field_parser (
  input  wire       clk_i,
  input  wire       rst_ni,
  hsfp_in_if.sink   byte_i,
  hsfp_out_if.source result_o
);
  import hsfp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_first_q;
  logic         in_last_q;
  parse_state_t state_q;
  parse_state_t state_d;
  logic         out_valid_q;
  result_t      out_res_q;
  result_t      dec_res;
  logic         dec_emit;
  logic         advance;
  logic         in_xfer;

  // The input register moves on once the result register is free or drains.
  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign byte_i.ready   = !in_valid_q || advance;
  assign in_xfer        = byte_i.valid && byte_i.ready;

  hsfp_byte_decode u_decode (
    .state_i      (state_q),
    .data_byte_i  (in_byte_q),
    .first_byte_i (in_first_q),
    .last_byte_i  (in_last_q),
    .state_o      (state_d),
    .emit_o       (dec_emit),
    .result_o     (dec_res)
  );

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q  <= byte_i.data_byte;
      in_first_q <= byte_i.first_byte;
      in_last_q  <= byte_i.last_byte;
    end
  end

  // Parser state; after reset it waits for a first byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{done: 1'b1, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= dec_emit;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && dec_emit) begin
      out_res_q <= dec_res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.status         = out_res_q.status;
  assign result_o.frame_num_bits = out_res_q.frame_num_bits;
  assign result_o.poc_mode       = out_res_q.poc_mode;
  assign result_o.poc_lsb_bits   = out_res_q.poc_lsb_bits;
  assign result_o.frame_mbs_only = out_res_q.frame_mbs_only;

  // A result always ends the parse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dec_emit) |=> state_q.done)
    else $error("parse still running after a result");

  // A suffix never runs longer than its prefix, which stays within the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.suffix_left <= state_q.lz_cnt) && (state_q.lz_cnt <= MAX_LEADING_ZEROS))
    else $error("exp-Golomb counters out of range");

  // A good result never carries the invalid POC type.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.status == ST_OK) |-> (result_o.poc_mode != 2'd3))
    else $error("status OK with invalid POC type");

  // The POC LSB size is only reported for POC type 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.poc_mode != 2'd0) |-> (result_o.poc_lsb_bits == 6'd0))
    else $error("POC LSB size given for nonzero POC type");

endmodule

`default_nettype wire

### rtl/core/hsfp_bit_step.sv
// Decode of one SPS bit: exp-Golomb prefix and suffix handling and field sequencing.
`timescale 1ns / 1ps
`default_nettype none

module hsfp_bit_step (
  input  hsfp_pkg::parse_state_t state_i,
  input  logic                   active_i,
  input  logic                   bit_i,
  output hsfp_pkg::parse_state_t state_o,
  output hsfp_pkg::bit_res_t     res_o
);
  import hsfp_pkg::*;

  logic        do_code;
  logic [32:0] code_w;
  logic [31:0] code_sh;
  logic [5:0]  size_v;
  logic [31:0] cyc_dec;

  assign code_sh = {state_i.code[30:0], bit_i};
  assign cyc_dec = state_i.cycle_left - 32'd1;

  // The finished code value is code_w - 1, where code_w is the suffix with
  // its leading one put back.
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    do_code = 1'b0;
    code_w  = 33'd1;
    size_v  = '0;

    if (active_i) begin
      if (state_i.step == STEP_DELTA_FLAG) begin
        state_o.step = STEP_OFS_NONREF;
      end else if (state_i.step == STEP_GAPS_FLAG) begin
        state_o.step = STEP_MB_WIDTH;
      end else if (state_i.step == STEP_MBS_FLAG) begin
        res_o.emit   = 1'b1;
        res_o.status = ST_OK;
        res_o.mbs    = bit_i;
      end else if (state_i.suffix_left == '0) begin
        // Prefix: count zeros until the marker one.
        if (!bit_i) begin
          if (state_i.lz_cnt >= MAX_LEADING_ZEROS) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_LONG_EXP;
          end else begin
            state_o.lz_cnt = state_i.lz_cnt + 6'd1;
          end
        end else if (state_i.lz_cnt == '0) begin
          do_code = 1'b1;
          code_w  = 33'd1;
        end else begin
          state_o.suffix_left = state_i.lz_cnt;
          state_o.code        = '0;
        end
      end else begin
        // Suffix: shift in bits until the count runs out.
        state_o.code        = code_sh;
        state_o.suffix_left = state_i.suffix_left - 6'd1;
        if (state_i.suffix_left == 6'd1) begin
          do_code             = 1'b1;
          code_w              = {1'b0, code_sh} | (33'd1 << state_i.lz_cnt);
          state_o.lz_cnt      = '0;
          state_o.code        = '0;
        end
      end
    end

    // Size fields: value plus four, saturated at 63.
    size_v = (code_w >= 33'd60) ? 6'd63 : (code_w[5:0] + 6'd3);

    // Act on a finished code according to the field being decoded.
    if (do_code) begin
      unique case (state_i.step)
        STEP_SPS_ID: state_o.step = STEP_FRAME_NUM;
        STEP_FRAME_NUM: begin
          state_o.fn_size = size_v;
          state_o.step    = STEP_POC_TYPE;
        end
        STEP_POC_TYPE: begin
          if (code_w > 33'd3) begin
            state_o.poc_kind = 2'd3;
            res_o.emit       = 1'b1;
            res_o.status     = ST_BAD_POC;
          end else begin
            state_o.poc_kind = code_w[1:0] - 2'd1;
            if (code_w == 33'd1) begin
              state_o.step = STEP_POC_LSB;
            end else if (code_w == 33'd2) begin
              state_o.step = STEP_DELTA_FLAG;
            end else begin
              state_o.step = STEP_REF_FRAMES;
            end
          end
        end
        STEP_POC_LSB: begin
          state_o.lsb_size = size_v;
          state_o.step     = STEP_REF_FRAMES;
        end
        STEP_OFS_NONREF: state_o.step = STEP_OFS_T2B;
        STEP_OFS_T2B:    state_o.step = STEP_CYCLE_LEN;
        STEP_CYCLE_LEN: begin
          if (code_w == 33'd1) begin
            state_o.step = STEP_REF_FRAMES;
          end else begin
            // Counts above 32 bits saturate.
            state_o.cycle_left = code_w[32] ? '1 : (code_w[31:0] - 32'd1);
            state_o.step       = STEP_CYCLE_ITEM;
          end
        end
        STEP_CYCLE_ITEM: begin
          state_o.cycle_left = cyc_dec;
          if (cyc_dec == '0) begin
            state_o.step = STEP_REF_FRAMES;
          end
        end
        STEP_REF_FRAMES: state_o.step = STEP_GAPS_FLAG;
        STEP_MB_WIDTH:   state_o.step = STEP_MB_HEIGHT;
        STEP_MB_HEIGHT:  state_o.step = STEP_MBS_FLAG;
        default:         state_o.done = 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsfp_byte_decode.sv
// Decode of one SPS byte: restart, header skip and a chain of eight bit steps.
`timescale 1ns / 1ps
`default_nettype none

module hsfp_byte_decode (
  input  hsfp_pkg::parse_state_t state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_byte_i,
  input  logic                   last_byte_i,
  output hsfp_pkg::parse_state_t state_o,
  output logic                   emit_o,
  output hsfp_pkg::result_t      result_o
);
  import hsfp_pkg::*;

  parse_state_t start_st;
  parse_state_t chain_st [0:8];
  bit_res_t     bit_res  [0:7];
  logic         emitted  [0:8];
  logic [1:0]   em_status[0:8];
  logic         em_mbs   [0:8];
  logic         decode_bits;

  // A first byte drops whatever parse was running.
  always_comb begin
    start_st = state_i;
    if (first_byte_i) begin
      start_st = '0;
    end
  end

  assign decode_bits = !start_st.done && (start_st.skip_cnt >= HEADER_SKIP_BYTES);

  assign chain_st[0]  = start_st;
  assign emitted[0]   = 1'b0;
  assign em_status[0] = ST_OK;
  assign em_mbs[0]    = 1'b0;

  // Bits go MSB first; after the first result later bits do nothing.
  for (genvar i = 0; i < 8; i++) begin : g_bit
    hsfp_bit_step u_step (
      .state_i  (chain_st[i]),
      .active_i (decode_bits && !chain_st[i].done && !emitted[i]),
      .bit_i    (data_byte_i[7 - i]),
      .state_o  (chain_st[i + 1]),
      .res_o    (bit_res[i])
    );
    assign emitted[i + 1]   = emitted[i] | bit_res[i].emit;
    assign em_status[i + 1] = bit_res[i].emit ? bit_res[i].status : em_status[i];
    assign em_mbs[i + 1]    = bit_res[i].emit ? bit_res[i].mbs : em_mbs[i];
  end

  // Header skip, truncation and result assembly.
  always_comb begin
    state_o  = start_st;
    emit_o   = 1'b0;
    result_o = '0;
    if (!start_st.done) begin
      if (!decode_bits) begin
        state_o.skip_cnt = start_st.skip_cnt + 2'd1;
      end else begin
        state_o = chain_st[8];
      end
      if (decode_bits && emitted[8]) begin
        emit_o          = 1'b1;
        result_o.status = em_status[8];
      end else if (!state_o.done && last_byte_i) begin
        emit_o          = 1'b1;
        result_o.status = ST_TRUNC;
      end
      result_o.frame_num_bits = state_o.fn_size;
      result_o.poc_mode       = state_o.poc_kind;
      result_o.poc_lsb_bits   = (state_o.poc_kind == 2'd0) ? state_o.lsb_size : 6'd0;
      result_o.frame_mbs_only = (result_o.status == ST_OK) ? em_mbs[8] : 1'b0;
      if (emit_o) begin
        state_o.done = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### tb/tb_h264_sps_field_parser.sv
// Self-checking testbench of the H.264 SPS field parser with a built-in SPS decoder model.
`timescale 1ns / 1ps

module tb_h264_sps_field_parser;
  import hsfp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_BYTES   = 550;
  localparam int unsigned DRAIN_SPACING  = 120;

  // One entry of the byte stream; a drain entry holds the sender until all results are in.
  typedef struct packed {
    logic       drain;
    logic [7:0] data;
    logic       first;
    logic       last;
  } sps_byte_t;

  logic clk_i;
  logic rst_ni;

  hsfp_in_if  byte_if ();
  hsfp_out_if result_if ();

  h264_sps_field_parser uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  // Stimulus and scoreboard storage.
  sps_byte_t   sps_byte_queue[$];
  result_t     sps_results_due[$];
  bit          sps_bits[$];
  sps_byte_t   next_byte;
  int unsigned bytes_offered;
  int unsigned bytes_accepted;
  int unsigned sps_bytes_built;
  int unsigned fail_count;
  int unsigned tx_gap;
  int unsigned tx_burst;
  int unsigned rx_stall;
  int unsigned rx_burst;
  int unsigned idle_cycles;
  bit          rx_settle;

  // Decoder model state.
  logic [1:0]  ps_skip;
  logic [3:0]  ps_step;
  logic [5:0]  ps_zeros;
  logic [5:0]  ps_suffix_left;
  logic [32:0] ps_code;
  logic [31:0] ps_cycle_left;
  logic [5:0]  ps_fn_size;
  logic [1:0]  ps_poc_kind;
  logic [5:0]  ps_lsb_size;
  logic        ps_idle;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------------------

  // Sizes are coded minus 4 and saturate at 63.
  function automatic logic [5:0] size_plus4(input logic [63:0] v);
    return (v >= 64'd59) ? 6'd63 : (v[5:0] + 6'd4);
  endfunction

  function automatic void restart_parse();
    ps_skip        = '0;
    ps_step        = STEP_SPS_ID;
    ps_zeros       = '0;
    ps_suffix_left = '0;
    ps_code        = '0;
    ps_cycle_left  = '0;
    ps_fn_size     = '0;
    ps_poc_kind    = '0;
    ps_lsb_size    = '0;
    ps_idle        = 1'b0;
  endfunction

  // Advances the syntax position once a whole exp-Golomb code has been decoded.
  function automatic void end_of_code(input logic [63:0] v, output logic hit,
                                      output logic [1:0] st);
    hit = 1'b0;
    st  = ST_OK;
    case (ps_step)
      STEP_SPS_ID: ps_step = STEP_FRAME_NUM;
      STEP_FRAME_NUM: begin
        ps_fn_size = size_plus4(v);
        ps_step    = STEP_POC_TYPE;
      end
      STEP_POC_TYPE: begin
        if (v > 64'd2) begin
          ps_poc_kind = 2'd3;
          hit         = 1'b1;
          st          = ST_BAD_POC;
        end else begin
          ps_poc_kind = v[1:0];
          ps_step = (v == 64'd0) ? STEP_POC_LSB :
                    (v == 64'd1) ? STEP_DELTA_FLAG : STEP_REF_FRAMES;
        end
      end
      STEP_POC_LSB: begin
        ps_lsb_size = size_plus4(v);
        ps_step     = STEP_REF_FRAMES;
      end
      STEP_OFS_NONREF: ps_step = STEP_OFS_T2B;
      STEP_OFS_T2B:    ps_step = STEP_CYCLE_LEN;
      STEP_CYCLE_LEN: begin
        if (v == 64'd0) begin
          ps_step = STEP_REF_FRAMES;
        end else begin
          ps_cycle_left = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
          ps_step       = STEP_CYCLE_ITEM;
        end
      end
      STEP_CYCLE_ITEM: begin
        ps_cycle_left = ps_cycle_left - 32'd1;
        if (ps_cycle_left == 32'd0) ps_step = STEP_REF_FRAMES;
      end
      STEP_REF_FRAMES: ps_step = STEP_GAPS_FLAG;
      STEP_MB_WIDTH:   ps_step = STEP_MB_HEIGHT;
      STEP_MB_HEIGHT:  ps_step = STEP_MBS_FLAG;
      default:         ps_idle = 1'b1;
    endcase
  endfunction

  // Consumes one payload bit: single flag bits, or one bit of an exp-Golomb code.
  function automatic void take_bit(input logic b, output logic hit, output logic [1:0] st,
                                   output logic mbs);
    logic [63:0] v;
    hit = 1'b0;
    st  = ST_OK;
    mbs = 1'b0;
    if (ps_step == STEP_DELTA_FLAG) begin
      ps_step = STEP_OFS_NONREF;
    end else if (ps_step == STEP_GAPS_FLAG) begin
      ps_step = STEP_MB_WIDTH;
    end else if (ps_step == STEP_MBS_FLAG) begin
      mbs = b;
      hit = 1'b1;
    end else if (ps_suffix_left == 6'd0) begin
      if (!b) begin
        if (ps_zeros >= MAX_LEADING_ZEROS) begin
          hit = 1'b1;
          st  = ST_LONG_EXP;
        end else begin
          ps_zeros = ps_zeros + 6'd1;
        end
      end else if (ps_zeros == 6'd0) begin
        end_of_code(64'd0, hit, st);
      end else begin
        ps_suffix_left = ps_zeros;
        ps_code        = '0;
      end
    end else begin
      ps_code        = {ps_code[31:0], b};
      ps_suffix_left = ps_suffix_left - 6'd1;
      if (ps_suffix_left == 6'd0) begin
        v        = ((64'd1 << ps_zeros) - 64'd1) + {31'd0, ps_code};
        ps_zeros = '0;
        ps_code  = '0;
        end_of_code(v, hit, st);
      end
    end
  endfunction

  // Queues the result of the current parse and stops until the next first byte.
  function automatic void post_result(input logic [1:0] st, input logic mbs);
    result_t r;
    r.status         = st;
    r.frame_num_bits = ps_fn_size;
    r.poc_mode       = ps_poc_kind;
    r.poc_lsb_bits   = (ps_poc_kind == 2'd0) ? ps_lsb_size : 6'd0;
    r.frame_mbs_only = (st == ST_OK) ? mbs : 1'b0;
    sps_results_due.push_back(r);
    ps_idle = 1'b1;
  endfunction

  // Applies one transferred byte to the model.
  function automatic void parse_sps_byte(input logic [7:0] data, input logic first,
                                         input logic last);
    logic       hit;
    logic [1:0] st;
    logic       mbs;
    logic       stop;
    stop = 1'b0;
    if (first) restart_parse();
    if (!ps_idle) begin
      if (ps_skip < HEADER_SKIP_BYTES) begin
        ps_skip = ps_skip + 2'd1;
      end else begin
        for (int i = 7; i >= 0 && !stop; i--) begin
          take_bit(data[i], hit, st, mbs);
          if (hit) begin
            post_result(st, mbs);
            stop = 1'b1;
          end else if (ps_idle) begin
            stop = 1'b1;
          end
        end
      end
      if (!stop && last) post_result(ST_TRUNC, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // SPS stream builder
  // ---------------------------------------------------------------------------------------

  // Appends the n low bits of val, MSB first.
  function automatic void put_bits(input logic [63:0] val, input int n);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(val[i]);
  endfunction

  // Appends the unsigned exp-Golomb code of v.
  function automatic void put_ue(input logic [63:0] v);
    logic [63:0] vp;
    int          n;
    vp = v + 64'd1;
    n  = 0;
    while ((vp >> (n + 1)) != 64'd0) n++;
    put_bits(64'd0, n);
    put_bits(vp, n + 1);
  endfunction

  // Appends a code of random length, mostly short, now and then the longest legal one.
  function automatic void put_rand_code();
    int unsigned r;
    int unsigned nz;
    logic [63:0] suffix;
    r = $urandom_range(0, 99);
    if (r < 55) nz = $urandom_range(0, 1);
    else if (r < 85) nz = $urandom_range(2, 5);
    else if (r < 95) nz = $urandom_range(6, 30);
    else nz = MAX_LEADING_ZEROS;
    suffix = {$urandom, $urandom} & ((64'd1 << nz) - 64'd1);
    put_bits(64'd0, nz);
    put_bits((64'd1 << nz) | suffix, nz + 1);
  endfunction

  // Packs the pending bits behind random header bytes and queues the frame.
  // keep > 0 keeps that many bytes, keep < 0 cuts at a random point, 0 keeps all.
  function automatic void flush_sps(input int keep, input bit mark_last);
    logic [7:0] frame[$];
    logic [7:0] byte_v;
    sps_byte_t  b;
    int         n;
    for (int h = 0; h < HEADER_SKIP_BYTES; h++) frame.push_back(8'($urandom));
    while (sps_bits.size() % 8 != 0) sps_bits.push_back(1'($urandom));
    for (int i = 0; i < sps_bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) byte_v[7 - j] = sps_bits[i + j];
      frame.push_back(byte_v);
    end
    sps_bits.delete();
    if (keep > 0) n = (keep < frame.size()) ? keep : frame.size();
    else if (keep < 0) n = $urandom_range(1, frame.size() - 1);
    else n = frame.size();
    for (int i = 0; i < n; i++) begin
      b.drain = 1'b0;
      b.data  = frame[i];
      b.first = (i == 0);
      b.last  = mark_last && (i == n - 1);
      sps_byte_queue.push_back(b);
    end
    sps_bytes_built += n;
  endfunction

  function automatic void push_raw_byte(input logic [7:0] data, input logic first,
                                        input logic last);
    sps_byte_t b;
    b.drain = 1'b0;
    b.data  = data;
    b.first = first;
    b.last  = last;
    sps_byte_queue.push_back(b);
  endfunction

  function automatic void push_drain();
    sps_byte_t b;
    b       = '0;
    b.drain = 1'b1;
    sps_byte_queue.push_back(b);
  endfunction

  // One SPS with random content; most are well formed, some are cut, broken or abandoned.
  function automatic void build_random_sps();
    int unsigned r;
    int unsigned poc;
    int unsigned cycle_len;
    put_rand_code();
    if ($urandom_range(0, 99) < 5) begin
      // Over-long code somewhere in the first few fields.
      repeat ($urandom_range(0, 3)) put_rand_code();
      put_bits(64'd0, 32 + $urandom_range(0, 8));
    end else begin
      put_rand_code();
      r = $urandom_range(0, 99);
      poc = (r < 38) ? 0 : (r < 63) ? 1 : (r < 88) ? 2 : 3 + $urandom_range(0, 60);
      put_ue(poc);
      if (poc == 0) begin
        put_rand_code();
      end else if (poc == 1) begin
        put_bits(64'($urandom), 1);
        put_rand_code();
        put_rand_code();
        cycle_len = $urandom_range(0, 4);
        put_ue(cycle_len);
        repeat (cycle_len) put_rand_code();
      end
      put_rand_code();
      put_bits(64'($urandom), 1);
      put_rand_code();
      put_rand_code();
      put_bits(64'($urandom), 1);
      if ($urandom_range(0, 4) == 0) put_bits({$urandom, $urandom}, $urandom_range(0, 16));
    end
    r = $urandom_range(0, 99);
    if (r < 65) flush_sps(0, 1'b1);
    else if (r < 80) flush_sps(-1, 1'b1);
    else if (r < 92) flush_sps(0, 1'b0);
    else flush_sps(-1, 1'b0);
  endfunction

  // Idle length: mostly short, a few long, and now and then a stretch without idling.
  function automatic int unsigned draw_gap(inout int unsigned burst_left);
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(30, 90);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 2);
    else if (r < 96) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: byte source and result ready, both changed at the falling edge
  // ---------------------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_if.valid   <= 1'b0;
      result_if.ready <= 1'b0;
    end else begin
      // Byte side: hold until the transfer, then idle or move to the next entry.
      if (byte_if.valid && bytes_accepted != bytes_offered) begin
        // Waiting for the transfer of the current byte.
      end else if (tx_gap != 0) begin
        byte_if.valid <= 1'b0;
        tx_gap--;
      end else if (sps_byte_queue.size() == 0) begin
        byte_if.valid <= 1'b0;
      end else if (sps_byte_queue[0].drain) begin
        byte_if.valid <= 1'b0;
        if (sps_results_due.size() == 0) void'(sps_byte_queue.pop_front());
      end else begin
        next_byte = sps_byte_queue.pop_front();
        byte_if.valid      <= 1'b1;
        byte_if.data_byte  <= next_byte.data;
        byte_if.first_byte <= next_byte.first;
        byte_if.last_byte  <= next_byte.last;
        bytes_offered++;
        tx_gap = draw_gap(tx_burst);
      end

      // Result side: random stalls, always ready once the stimulus is over.
      if (rx_settle) begin
        result_if.ready <= 1'b1;
      end else if (rx_stall != 0) begin
        result_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        result_if.ready <= 1'b1;
        rx_stall = draw_gap(rx_burst);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: results are checked before the byte of the same edge is applied to the model
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [5:0] exp_v,
                                      input logic [5:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready) begin
      if (sps_results_due.size() == 0) begin
        $error("result transfer with none due: status %0d", result_if.status);
        fail_count++;
      end else begin
        check_field("status", 6'(sps_results_due[0].status), 6'(result_if.status));
        check_field("frame_num_bits", sps_results_due[0].frame_num_bits,
                    result_if.frame_num_bits);
        check_field("poc_mode", 6'(sps_results_due[0].poc_mode), 6'(result_if.poc_mode));
        check_field("poc_lsb_bits", sps_results_due[0].poc_lsb_bits,
                    result_if.poc_lsb_bits);
        check_field("frame_mbs_only", 6'(sps_results_due[0].frame_mbs_only),
                    6'(result_if.frame_mbs_only));
        void'(sps_results_due.pop_front());
      end
    end
    if (byte_if.valid && byte_if.ready) begin
      parse_sps_byte(byte_if.data_byte, byte_if.first_byte, byte_if.last_byte);
      bytes_accepted++;
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[h264_sps_field_parser] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.data_byte    = 8'h00;
    byte_if.first_byte   = 1'b0;
    byte_if.last_byte    = 1'b0;
    result_if.ready      = 1'b0;
    bytes_offered        = 0;
    bytes_accepted       = 0;
    sps_bytes_built      = 0;
    fail_count           = 0;
    tx_gap               = 0;
    tx_burst             = 0;
    rx_stall             = 0;
    rx_burst             = 0;
    rx_settle            = 1'b0;
    restart_parse();
    ps_idle = 1'b1;

    // Byte while idle, even with last_byte set, is ignored.
    push_raw_byte(8'hFF, 1'b0, 1'b1);
    // POC type 0, frame number size at the saturation boundary (59 -> 63), LSB size 55 -> 59.
    put_ue(0); put_ue(59); put_ue(0); put_ue(55); put_ue(0); put_bits(64'd0, 1);
    put_ue(0); put_ue(0); put_bits(64'd1, 1);
    flush_sps(0, 1'b1);
    // POC type 1 with a two-entry offset cycle.
    put_ue(0); put_ue(0); put_ue(1); put_bits(64'd1, 1); put_ue(0); put_ue(0);
    put_ue(2); put_ue(0); put_ue(0); put_ue(0); put_bits(64'd0, 1);
    put_ue(0); put_ue(0); put_bits(64'd0, 1);
    flush_sps(0, 1'b1);
    // Truncation inside the header.
    put_ue(0);
    flush_sps(2, 1'b1);
    // Abandoned header, dropped by the restart of the next SPS.
    put_ue(0);
    flush_sps(2, 1'b0);
    // Invalid POC type in the middle of a byte; the rest of the byte is ignored.
    put_ue(0); put_ue(0); put_ue(5);
    flush_sps(0, 1'b1);
    // More leading zeros than allowed in the very first code.
    put_bits(64'd0, 32);
    flush_sps(0, 1'b1);
    push_drain();

    // Random part: mostly well-formed SPS, some noise bytes and junk runs.
    sps_bytes_built = 0;
    while (sps_bytes_built < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 6) begin
        push_raw_byte(8'($urandom), 1'b0, 1'($urandom));
      end else if ($urandom_range(0, 99) < 5) begin
        repeat ($urandom_range(0, 5)) put_bits(64'($urandom), 8);
        flush_sps(0, 1'($urandom));
      end else begin
        build_random_sps();
      end
      if (sps_bytes_built / DRAIN_SPACING != (sps_bytes_built + 12) / DRAIN_SPACING)
        push_drain();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (sps_byte_queue.size() != 0 || bytes_accepted != bytes_offered) @(negedge clk_i);
    while (sps_results_due.size() != 0) @(negedge clk_i);
    rx_settle = 1'b1;
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[h264_sps_field_parser] OK");
    end else begin
      $display("[h264_sps_field_parser] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/hsfp_pkg.sv
rtl/core/hsfp_in_if.sv
rtl/core/hsfp_out_if.sv
rtl/core/hsfp_bit_step.sv
rtl/core/hsfp_byte_decode.sv
rtl/core/h264_sps_field_parser.sv
tb/tb_h264_sps_field_parser.sv
